/* design/clse_pkg.sv */
// ----------------------------------------------------------------------------
// clse_pkg: shared types and constants for the Chebyshev series evaluator
// Holds field widths, command and register codes, fixed-point limits, the
// controller state type and the control structs passed between modules.
// ----------------------------------------------------------------------------
package clse_pkg;

  // Payload field widths.
  localparam int CMD_W   = 1;
  localparam int POLY_W  = 2;
  localparam int CIDX_W  = 5;
  localparam int COEF_W  = 32;
  localparam int POINT_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int NCOEF_W    = 6;
  localparam int NPOLY_W    = 3;

  // Recurrence arithmetic.
  localparam int B_W   = 48;
  localparam int ACC_W = 52;
  localparam int PROD_W = 64;
  localparam int LO_W  = 24;

  // Item commands.
  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_EVAL = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COEFFS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLYS  = 2'd1;

  // Point range, Q2.14 minus one to plus one.
  localparam logic signed [POINT_W-1:0] X_MAX = 16'sd16384;
  localparam logic signed [POINT_W-1:0] X_MIN = -16'sd16384;

  // Saturation bounds of the 48-bit recurrence, held at accumulator width.
  localparam logic signed [ACC_W-1:0] B_HI = {{(ACC_W-B_W+1){1'b0}}, {(B_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] B_LO = {{(ACC_W-B_W+1){1'b1}}, {(B_W-1){1'b0}}};

  // Saturation bounds of the 32-bit result, held at recurrence width.
  localparam logic signed [B_W-1:0] Y_HI = {{(B_W-COEF_W+1){1'b0}}, {(COEF_W-1){1'b1}}};
  localparam logic signed [B_W-1:0] Y_LO = {{(B_W-COEF_W+1){1'b1}}, {(COEF_W-1){1'b0}}};

  // Rounding constants for the two product scalings.
  localparam logic signed [PROD_W-1:0] RND_STEP  = 64'sd4096;
  localparam logic signed [PROD_W-1:0] RND_FINAL = 64'sd8192;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ACC,
    ST_EMIT
  } clse_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              start_item;
    logic              clear_b;
    logic              mul;
    logic              sum;
    logic              acc;
    logic              final_step;
    logic              emit;
    logic [POLY_W-1:0] poly;
    logic              last;
  } clse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } clse_stat_t;

endpackage

/* design/clse_in_if.sv */
// ----------------------------------------------------------------------------
// clse_in_if: input item channel
// Valid/ready channel carrying one load or evaluate item per beat.
// ----------------------------------------------------------------------------
interface clse_in_if;
  import clse_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [POLY_W-1:0]         poly_select;
  logic [CIDX_W-1:0]         coefficient_index;
  logic signed [COEF_W-1:0]  coefficient_value;
  logic signed [POINT_W-1:0] point;

  modport source (
    output valid, command, poly_select, coefficient_index, coefficient_value, point,
    input  ready
  );
  modport sink (
    input  valid, command, poly_select, coefficient_index, coefficient_value, point,
    output ready
  );
endinterface

/* design/clse_out_if.sv */
// ----------------------------------------------------------------------------
// clse_out_if: result channel
// Valid/ready channel carrying one polynomial result per beat.
// ----------------------------------------------------------------------------
interface clse_out_if;
  import clse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [POLY_W-1:0]        poly_number;
  logic signed [COEF_W-1:0] series_value;
  logic                     overflowed;
  logic                     last_result;

  modport source (
    output valid, poly_number, series_value, overflowed, last_result,
    input  ready
  );
  modport sink (
    input  valid, poly_number, series_value, overflowed, last_result,
    output ready
  );
endinterface

/* design/clse_cfg_if.sv */
// ----------------------------------------------------------------------------
// clse_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface clse_cfg_if;
  import clse_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

/* design/clse_ram.sv */
// ----------------------------------------------------------------------------
// clse_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module clse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/clse_datapath.sv */
// ----------------------------------------------------------------------------
// clse_datapath: Clenshaw recurrence datapath
// Split multiplier, scaling and rounding, accumulate with saturation, and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module clse_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  clse_pkg::clse_cmd_t                cmd,
  output clse_pkg::clse_stat_t               stat,
  input  logic signed [clse_pkg::POINT_W-1:0] point,
  input  logic [clse_pkg::COEF_W-1:0]        coef,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [clse_pkg::POLY_W-1:0]        out_poly,
  output logic signed [clse_pkg::COEF_W-1:0] out_value,
  output logic                               out_ovf,
  output logic                               out_last
);
  import clse_pkg::*;

  logic signed [POINT_W-1:0]    x_r, x_nxt;
  logic signed [B_W-1:0]        b1_r, b1_nxt, b2_r, b2_nxt;
  logic                         ovf_r, ovf_nxt;
  logic signed [LO_W+POINT_W:0] lo_prod_r;
  logic signed [B_W-LO_W+POINT_W-1:0] hi_prod_r;
  logic signed [ACC_W-1:0]      scaled_r;
  logic signed [COEF_W-1:0]     res_r;
  logic                         res_ovf_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [POLY_W-1:0]            out_poly_r;
  logic signed [COEF_W-1:0]     out_value_r;
  logic                         out_ovf_r, out_last_r;

  logic signed [PROD_W-1:0] prod, prod_rnd, prod_shift;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [B_W-1:0]    b_sat;
  logic                     b_ovf;
  logic signed [COEF_W-1:0] y_sat;
  logic                     y_ovf;

  // Clamp the point into minus one to plus one.
  always_comb begin
    if (point > X_MAX) begin
      x_nxt = X_MAX;
    end else if (point < X_MIN) begin
      x_nxt = X_MIN;
    end else begin
      x_nxt = point;
    end
  end

  // Reassemble the split product, round half up, scale by 2x or x.
  always_comb begin
    prod       = (PROD_W'(hi_prod_r) <<< LO_W) + PROD_W'(lo_prod_r);
    prod_rnd   = prod + (cmd.final_step ? RND_FINAL : RND_STEP);
    prod_shift = cmd.final_step ? (prod_rnd >>> 14) : (prod_rnd >>> 13);
  end

  // Recurrence step with saturation to 48 and then 32 bits.
  always_comb begin
    acc_sum = scaled_r - ACC_W'(b2_r) + ACC_W'($signed(coef));
    b_ovf   = 1'b0;
    if (acc_sum > B_HI) begin
      b_sat = B_W'(B_HI);
      b_ovf = 1'b1;
    end else if (acc_sum < B_LO) begin
      b_sat = B_W'(B_LO);
      b_ovf = 1'b1;
    end else begin
      b_sat = B_W'(acc_sum);
    end
    y_ovf = 1'b0;
    if (b_sat > Y_HI) begin
      y_sat = COEF_W'(Y_HI);
      y_ovf = 1'b1;
    end else if (b_sat < Y_LO) begin
      y_sat = COEF_W'(Y_LO);
      y_ovf = 1'b1;
    end else begin
      y_sat = COEF_W'(b_sat);
    end
  end

  always_comb begin
    b1_nxt  = b1_r;
    b2_nxt  = b2_r;
    ovf_nxt = ovf_r;
    if (cmd.start_item || cmd.clear_b) begin
      b1_nxt  = '0;
      b2_nxt  = '0;
      ovf_nxt = 1'b0;
    end else if (cmd.acc && !cmd.final_step) begin
      b2_nxt  = b1_r;
      b1_nxt  = b_sat;
      ovf_nxt = ovf_r | b_ovf;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_item) begin
      x_r <= x_nxt;
    end
    b1_r  <= b1_nxt;
    b2_r  <= b2_nxt;
    ovf_r <= ovf_nxt;
    if (cmd.mul) begin
      lo_prod_r <= x_r * $signed({1'b0, b1_r[LO_W-1:0]});
      hi_prod_r <= x_r * $signed(b1_r[B_W-1:LO_W]);
    end
    if (cmd.sum) begin
      scaled_r <= ACC_W'(prod_shift);
    end
    if (cmd.acc && cmd.final_step) begin
      res_r     <= y_sat;
      res_ovf_r <= ovf_r | b_ovf | y_ovf;
    end
    if (cmd.emit) begin
      out_poly_r  <= cmd.poly;
      out_value_r <= res_r;
      out_ovf_r   <= res_ovf_r;
      out_last_r  <= cmd.last;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_poly      = out_poly_r;
  assign out_value     = out_value_r;
  assign out_ovf       = out_ovf_r;
  assign out_last      = out_last_r;

endmodule

/* design/clse_ctrl.sv */
// ----------------------------------------------------------------------------
// clse_ctrl: sequencer for the Clenshaw evaluation
// Walks polynomials and coefficient orders, issues table reads and steps
// the datapath through multiply, scale and accumulate phases.
// ----------------------------------------------------------------------------
module clse_ctrl #(
  parameter int MAX_COEFFS = 32,
  parameter int NUM_POLYS  = 4
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  input  logic [clse_pkg::CMD_W-1:0]               in_command,
  output logic                                     in_ready,
  input  logic [clse_pkg::NCOEF_W-1:0]             cfg_coeffs,
  input  logic [clse_pkg::NPOLY_W-1:0]             cfg_polys,
  input  clse_pkg::clse_stat_t                     stat,
  output clse_pkg::clse_cmd_t                      cmd,
  output logic                                     rd_en,
  output logic [$clog2(NUM_POLYS*MAX_COEFFS)-1:0]  rd_addr
);
  import clse_pkg::*;

  localparam int AW         = $clog2(NUM_POLYS * MAX_COEFFS);
  localparam int KW         = $clog2(MAX_COEFFS);
  localparam int POLY_LIMIT = (NUM_POLYS < 4) ? NUM_POLYS : 4;

  clse_state_t       state_r, state_nxt;
  logic [KW-1:0]     k_r, k_nxt, kinit_r, kinit_nxt;
  logic [POLY_W-1:0] poly_r, poly_nxt, last_poly_r, last_poly_nxt;
  logic [KW-1:0]     kinit_calc;
  logic [POLY_W-1:0] last_calc;
  logic              start, is_last, final_step;

  // Effective top order and last polynomial from the registers.
  always_comb begin
    if (cfg_coeffs == '0) begin
      kinit_calc = '0;
    end else if (32'(cfg_coeffs) > MAX_COEFFS) begin
      kinit_calc = KW'(MAX_COEFFS - 1);
    end else begin
      kinit_calc = KW'(cfg_coeffs - NCOEF_W'(1));
    end
    if (cfg_polys == '0) begin
      last_calc = '0;
    end else if (32'(cfg_polys) > POLY_LIMIT) begin
      last_calc = POLY_W'(POLY_LIMIT - 1);
    end else begin
      last_calc = POLY_W'(cfg_polys - NPOLY_W'(1));
    end
  end

  assign start      = (state_r == ST_IDLE) && in_valid && (in_command == CMD_EVAL);
  assign is_last    = (poly_r == last_poly_r);
  assign final_step = (k_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = final_step ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = is_last ? ST_IDLE : ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    rd_en          = 1'b0;
    cmd.poly       = poly_r;
    cmd.last       = is_last;
    cmd.final_step = final_step;
    case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load       = in_valid && (in_command == CMD_LOAD);
        cmd.start_item = start;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        rd_en   = 1'b1;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit    = stat.out_free;
        cmd.clear_b = stat.out_free && !is_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign rd_addr = AW'(32'(poly_r) * MAX_COEFFS + 32'(k_r));

  // Counters.
  always_comb begin
    k_nxt         = k_r;
    kinit_nxt     = kinit_r;
    poly_nxt      = poly_r;
    last_poly_nxt = last_poly_r;
    if (start) begin
      k_nxt         = kinit_calc;
      kinit_nxt     = kinit_calc;
      poly_nxt      = '0;
      last_poly_nxt = last_calc;
    end else if (state_r == ST_ACC && !final_step) begin
      k_nxt = k_r - KW'(1);
    end else if (state_r == ST_EMIT && stat.out_free && !is_last) begin
      k_nxt    = kinit_r;
      poly_nxt = poly_r + POLY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      kinit_r     <= '0;
      poly_r      <= '0;
      last_poly_r <= '0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      kinit_r     <= kinit_nxt;
      poly_r      <= poly_nxt;
      last_poly_r <= last_poly_nxt;
    end
  end

endmodule

/* design/chebyshev_series_eval.sv */
// ----------------------------------------------------------------------------
// chebyshev_series_eval: fixed-point Chebyshev series evaluator
// Clenshaw recurrence over a table of up to NUM_POLYS series, one result
// beat per polynomial in use for every evaluate item.
// ----------------------------------------------------------------------------
// Usage. The in_chan channel takes one item per beat. A load item writes one
// Q16.16 coefficient into the table and is done in the cycle it is accepted;
// a load outside the table is dropped. An evaluate item carries a Q2.14 point
// and produces one beat on out_chan per polynomial in use, in polynomial
// order, with last_result set on the final one. The cfg_chan channel is
// always ready and writes the coefficient count and the polynomial count.
// Sequence. Each recurrence step is a registered multiply on a split
// 16 x 48 product, then a scale-and-round phase, then an accumulate with
// saturation; each polynomial ends with an emit phase. A single shared
// multiply-accumulate path serves every step, so in_chan takes no new item
// until the last result of the current evaluate item has been handed over.
// Reset clears control state and sets both counts to one. The table is not
// cleared; coefficients must be loaded before they are used. A result waits
// in the output register; if the receiver stalls, the sequencer holds before
// handing over the next result and the work stops until the beat is taken.
// ----------------------------------------------------------------------------
module chebyshev_series_eval #(
  parameter int MAX_COEFFS = 32,
  parameter int NUM_POLYS  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  clse_in_if.sink     in_chan,
  clse_out_if.source  out_chan,
  clse_cfg_if.sink    cfg_chan
);
  import clse_pkg::*;

  localparam int DEPTH = NUM_POLYS * MAX_COEFFS;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers.
  logic [NCOEF_W-1:0] coeffs_r, coeffs_nxt;
  logic [NPOLY_W-1:0] polys_r, polys_nxt;

  clse_cmd_t         ctl_cmd;
  clse_stat_t        ctl_stat;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [COEF_W-1:0] ram_rdata;

  // The configuration port never stalls; an index past the list is dropped.
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    coeffs_nxt = coeffs_r;
    polys_nxt  = polys_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_COEFFS: begin
          coeffs_nxt = cfg_chan.data[NCOEF_W-1:0];
        end
        CFG_POLYS: begin
          polys_nxt = cfg_chan.data[NPOLY_W-1:0];
        end
        default: begin
          coeffs_nxt = coeffs_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeffs_r <= NCOEF_W'(1);
      polys_r  <= NPOLY_W'(1);
    end else begin
      coeffs_r <= coeffs_nxt;
      polys_r  <= polys_nxt;
    end
  end

  // A coefficient load goes straight to the table when it lands inside it.
  // Reads only happen in the multiply phase, so the two never collide.
  assign ram_we = ctl_cmd.load
               && (32'(in_chan.poly_select) < NUM_POLYS)
               && (32'(in_chan.coefficient_index) < MAX_COEFFS);
  assign ram_waddr = AW'(32'(in_chan.poly_select) * MAX_COEFFS
                        + 32'(in_chan.coefficient_index));

  clse_ram #(
    .WIDTH (COEF_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_chan.coefficient_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  clse_ctrl #(
    .MAX_COEFFS (MAX_COEFFS),
    .NUM_POLYS  (NUM_POLYS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .cfg_coeffs (coeffs_r),
    .cfg_polys  (polys_r),
    .stat       (ctl_stat),
    .cmd        (ctl_cmd),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  // The table read issued in the multiply phase is held stable through the
  // scale and accumulate phases; the datapath consumes it in the accumulate phase.
  clse_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ctl_cmd),
    .stat      (ctl_stat),
    .point     (in_chan.point),
    .coef      (ram_rdata),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_poly  (out_chan.poly_number),
    .out_value (out_chan.series_value),
    .out_ovf   (out_chan.overflowed),
    .out_last  (out_chan.last_result)
  );

`ifndef ASSERT_OFF
  // A result is only handed over when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.emit |-> ctl_stat.out_free)
    else $error("result handed over while the output register was full");

  // A new result beat only appears after the sequencer emitted one.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(ctl_cmd.emit))
    else $error("result valid rose without an emit");

  // Table writes and reads never share a cycle.
  a_ram_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !rd_en)
    else $error("table write and read in the same cycle");

  // No item is taken while a multiply, scale or accumulate phase is in flight.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_cmd.mul || ctl_cmd.sum || ctl_cmd.acc) |-> !in_chan.ready)
    else $error("input ready while an evaluation is running");
`endif

endmodule

/* test/chebyshev_series_eval_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chebyshev_series_eval_test: self-checking bench for the series evaluator
// Drives load and evaluate beats with random idling on both channels. It
// predicts every result beat with its own fixed-point Clenshaw recurrence
// and compares each beat field by field, in order, against that prediction.
// ----------------------------------------------------------------------------
module chebyshev_series_eval_test;
  import clse_pkg::*;

  localparam int MAX_COEFFS = 32;
  localparam int NUM_POLYS  = 4;
  // The block never evaluates more than four polynomials per point.
  localparam int POLY_CAP   = (NUM_POLYS < 4) ? NUM_POLYS : 4;

  // Register indexes beyond the two real registers; writes there are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Recurrence values live in 48 bits, results in 32 bits.
  localparam longint B_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint B_BOTTOM = -B_TOP - 1;
  localparam longint Q_TOP    = 64'sd2147483647;
  localparam longint Q_BOTTOM = -64'sd2147483648;

  localparam logic signed [COEF_W-1:0] COEF_TOP    = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_BOTTOM = 32'sh8000_0000;

  // An evaluate beat with 32 coefficients and 4 polynomials keeps the block
  // busy longest; even so, a few hundred items finish far below this limit.
  localparam int unsigned LIMIT_CYCLES    = 1_000_000;
  localparam int          HOLD_OFF_CYCLES = 600;
  localparam int          SETTLE_CYCLES   = 16;

  typedef struct {
    logic [CMD_W-1:0]          command;
    logic [POLY_W-1:0]         poly_select;
    logic [CIDX_W-1:0]         coefficient_index;
    logic signed [COEF_W-1:0]  coefficient_value;
    logic signed [POINT_W-1:0] point;
  } series_item_t;

  typedef struct {
    logic [POLY_W-1:0]        poly_number;
    logic signed [COEF_W-1:0] series_value;
    logic                     overflowed;
    logic                     last_result;
  } series_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own coefficient table and register copies, turns
  // each accepted evaluate beat into the result beats it must produce and
  // checks result beats against them in arrival order.
  // --------------------------------------------------------------------------
  class clenshaw_checker;
    logic signed [COEF_W-1:0] coef_table [NUM_POLYS][MAX_COEFFS];
    logic [NCOEF_W-1:0]       coeffs_reg;
    logic [NPOLY_W-1:0]       polys_reg;
    series_result_t           pending_series [$];
    int unsigned              mismatches;
    int unsigned              results_seen;
    int unsigned              points_evaluated;
    int unsigned              saturations;

    function new();
      coeffs_reg       = NCOEF_W'(1);
      polys_reg        = NPOLY_W'(1);
      mismatches       = 0;
      results_seen     = 0;
      points_evaluated = 0;
      saturations      = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_COEFFS: coeffs_reg = data[NCOEF_W-1:0];
        CFG_POLYS:  polys_reg  = data[NPOLY_W-1:0];
        default: ;
      endcase
    endfunction

    function int active_coeffs();
      if (coeffs_reg == 0) return 1;
      if (coeffs_reg > MAX_COEFFS) return MAX_COEFFS;
      return int'(coeffs_reg);
    endfunction

    function int active_polys();
      if (polys_reg == 0) return 1;
      if (polys_reg > POLY_CAP) return POLY_CAP;
      return int'(polys_reg);
    endfunction

    // Product x * b scaled down by 2^sh, rounded half toward plus infinity.
    function longint round_scaled(longint x, longint b, int sh);
      return (x * b + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function longint clamp_b(longint v, inout bit sat);
      if (v > B_TOP) begin
        sat = 1'b1;
        return B_TOP;
      end
      if (v < B_BOTTOM) begin
        sat = 1'b1;
        return B_BOTTOM;
      end
      return v;
    endfunction

    // Clenshaw recurrence for one polynomial at point x (already clamped).
    function series_result_t clenshaw_sum(int poly, longint x, int ncoef);
      longint         b1;
      longint         b2;
      longint         nb;
      longint         y;
      bit             sat;
      series_result_t r;
      b1  = 0;
      b2  = 0;
      sat = 1'b0;
      for (int k = ncoef - 1; k >= 1; k--) begin
        nb = round_scaled(x, b1, 13) - b2 + longint'(coef_table[poly][k]);
        nb = clamp_b(nb, sat);
        b2 = b1;
        b1 = nb;
      end
      // The closing step uses x rather than 2x and adds the order-zero term.
      y = clamp_b(round_scaled(x, b1, 14) - b2 + longint'(coef_table[poly][0]), sat);
      if (y > Q_TOP) begin
        y   = Q_TOP;
        sat = 1'b1;
      end
      if (y < Q_BOTTOM) begin
        y   = Q_BOTTOM;
        sat = 1'b1;
      end
      r.poly_number  = poly[POLY_W-1:0];
      r.series_value = y[COEF_W-1:0];
      r.overflowed   = sat;
      r.last_result  = 1'b0;
      return r;
    endfunction

    function void note_item(series_item_t it);
      longint         x;
      int             np;
      series_result_t r;
      if (it.command == CMD_LOAD) begin
        coef_table[it.poly_select][it.coefficient_index] = it.coefficient_value;
        return;
      end
      x = longint'(it.point);
      if (x > X_MAX) x = longint'(X_MAX);
      if (x < X_MIN) x = longint'(X_MIN);
      np = active_polys();
      points_evaluated++;
      for (int p = 0; p < np; p++) begin
        r = clenshaw_sum(p, x, active_coeffs());
        r.last_result = (p == np - 1);
        pending_series.push_back(r);
      end
    endfunction

    function void compare_field(string field_name, logic [COEF_W-1:0] want,
                                logic [COEF_W-1:0] seen);
      if (seen !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, seen);
      end
    endfunction

    function void check_result(series_result_t got);
      series_result_t want;
      results_seen++;
      if (pending_series.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing pending, actual poly %0d value %0h",
                 $time, got.poly_number, got.series_value);
        return;
      end
      want = pending_series.pop_front();
      if (want.overflowed) saturations++;
      compare_field("poly_number", COEF_W'(want.poly_number), COEF_W'(got.poly_number));
      compare_field("series_value", want.series_value, got.series_value);
      compare_field("overflowed", COEF_W'(want.overflowed), COEF_W'(got.overflowed));
      compare_field("last_result", COEF_W'(want.last_result), COEF_W'(got.last_result));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  clse_in_if  in_if ();
  clse_out_if out_if ();
  clse_cfg_if cfg_if ();

  chebyshev_series_eval #(
    .MAX_COEFFS (MAX_COEFFS),
    .NUM_POLYS  (NUM_POLYS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  clenshaw_checker sb = new();

  // Shared stimulus state. While steady is set neither side idles. The
  // loaded map tells which table entries hold a value, so that an evaluate
  // beat is only sent once every coefficient it reads has been written.
  bit          steady       = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          loaded [NUM_POLYS][MAX_COEFFS];
  int unsigned beats_sent   = 0;
  int unsigned settings_run = 0;
  int unsigned cycles       = 0;

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the block or
  // the drivers update, so each handshake is seen exactly as it happened.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    series_item_t   it;
    series_result_t res;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_register(cfg_if.index, cfg_if.data);
      end
      if (out_if.valid && out_if.ready) begin
        res.poly_number  = out_if.poly_number;
        res.series_value = out_if.series_value;
        res.overflowed   = out_if.overflowed;
        res.last_result  = out_if.last_result;
        sb.check_result(res);
      end
      if (in_if.valid && in_if.ready) begin
        it.command           = in_if.command;
        it.poly_select       = in_if.poly_select;
        it.coefficient_index = in_if.coefficient_index;
        it.coefficient_value = in_if.coefficient_value;
        it.point             = in_if.point;
        sb.note_item(it);
      end
    end
  end

  // A run that hangs or loses result beats ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d result beats still pending",
               cycles, sb.pending_series.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. Ready drops in about a quarter of the cycles. Once, on
  // request from the stimulus, it holds ready low for a long counted stretch
  // so that the output register fills and the block stops taking input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    out_if.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_if.ready <= 1'b0;
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(posedge clk);
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= 26);
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Fields an item does not use still get random bits so every bit toggles.
  function automatic series_item_t load_item(int p, int k, logic signed [COEF_W-1:0] v);
    series_item_t it;
    it.command           = CMD_LOAD;
    it.poly_select       = p[POLY_W-1:0];
    it.coefficient_index = k[CIDX_W-1:0];
    it.coefficient_value = v;
    it.point             = POINT_W'($urandom);
    return it;
  endfunction

  function automatic series_item_t eval_item(logic signed [POINT_W-1:0] x);
    series_item_t it;
    it.command           = CMD_EVAL;
    it.poly_select       = POLY_W'($urandom);
    it.coefficient_index = CIDX_W'($urandom);
    it.coefficient_value = $urandom;
    it.point             = x;
    return it;
  endfunction

  // Mix of full-range, modest and extreme coefficients.
  function automatic logic signed [COEF_W-1:0] pick_coefficient();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? COEF_TOP : COEF_BOTTOM;
      default: return $signed(32'($urandom)) >>> $urandom_range(31, 8);
    endcase
  endfunction

  // Mostly points inside minus one to plus one, sometimes the ends, and
  // sometimes any 16-bit pattern, which the block clamps to the range.
  function automatic logic signed [POINT_W-1:0] pick_point();
    case ($urandom_range(7))
      0: return POINT_W'($urandom);
      1: return X_MAX;
      2: return X_MIN;
      default: return POINT_W'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // First table entry that the current setting reads but nobody has written.
  function automatic bit find_missing(output int p, output int k);
    for (p = 0; p < sb.active_polys(); p++) begin
      for (k = 0; k < sb.active_coeffs(); k++) begin
        if (!loaded[p][k]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic send_item(input series_item_t it);
    while (!steady && $urandom_range(99) < 26) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid             <= 1'b1;
    in_if.command           <= it.command;
    in_if.poly_select       <= it.poly_select;
    in_if.coefficient_index <= it.coefficient_index;
    in_if.coefficient_value <= it.coefficient_value;
    in_if.point             <= it.point;
    if (it.command == CMD_LOAD) loaded[it.poly_select][it.coefficient_index] = 1'b1;
    beats_sent++;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Waits until every predicted result beat has come back, then gives the
  // block a short pause so it is truly idle before the registers change.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_series.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // Raw register values go out unmasked; the block keeps the low bits and
  // clamps them, and the scoreboard does the same. Each setting also writes
  // one of the unused indexes, which must change nothing.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] coeffs,
                               input logic [CFG_DATA_W-1:0] polys);
    settle();
    write_reg(CFG_COEFFS, coeffs);
    write_reg(CFG_POLYS, polys);
    write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
    cfg_if.valid <= 1'b0;
    // Wait for the monitor to record the last write.
    @(posedge clk);
    settings_run++;
  endtask

  // One setting: fill whatever the setting reads that is still unwritten,
  // then a random mix of evaluate and load beats. With squeeze set, the
  // receiver is asked for its long hold-off partway through the phase.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] coeffs,
                           input logic [CFG_DATA_W-1:0] polys,
                           input int count, input bit calm, input bit squeeze);
    int p;
    int k;
    apply_setting(coeffs, polys);
    steady = calm;
    while (find_missing(p, k)) send_item(load_item(p, k, pick_coefficient()));
    for (int n = 0; n < count; n++) begin
      if (squeeze && n == count / 4) hold_off_req <= 1'b1;
      if ($urandom_range(99) < 60) begin
        send_item(eval_item(pick_point()));
      end else begin
        send_item(load_item($urandom_range(NUM_POLYS - 1), $urandom_range(MAX_COEFFS - 1),
                            pick_coefficient()));
      end
    end
    steady = 1'b0;
  endtask

  // Directed beats: coefficient extremes, both ends of the point range,
  // points outside the range that must clamp, the smallest nonzero point,
  // and a sum that saturates in the 32-bit result.
  task automatic directed_items();
    apply_setting(8'd1, 8'd1);
    send_item(load_item(0, 0, COEF_TOP));
    send_item(eval_item(X_MAX));
    send_item(eval_item(X_MIN));
    send_item(load_item(0, 0, COEF_BOTTOM));
    send_item(eval_item(16'sh7FFF));
    send_item(eval_item(16'sh8000));
    send_item(eval_item(16'sd0));

    // Two terms, two polynomials: at x = -1 polynomial zero is min - max,
    // which saturates the result.
    apply_setting(8'd2, 8'd2);
    send_item(load_item(0, 1, COEF_TOP));
    send_item(load_item(1, 0, COEF_BOTTOM));
    send_item(load_item(1, 1, COEF_BOTTOM));
    send_item(eval_item(X_MAX));
    send_item(eval_item(X_MIN));
    send_item(eval_item(16'sd8192));
    send_item(eval_item(16'sd1));
    send_item(load_item(1, 1, 32'sd0));
    send_item(eval_item(-16'sd8192));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    in_if.valid             <= 1'b0;
    in_if.command           <= CMD_LOAD;
    in_if.poly_select       <= '0;
    in_if.coefficient_index <= '0;
    in_if.coefficient_value <= '0;
    in_if.point             <= '0;
    cfg_if.valid            <= 1'b0;
    cfg_if.index            <= CFG_COEFFS;
    cfg_if.data             <= '0;
    foreach (loaded[p, k]) loaded[p][k] = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items();

    // Small sizes carry most of the run; the largest sizes only a few beats.
    run_phase(8'd4,  8'd1, 20, 1'b0, 1'b0);
    run_phase(8'd8,  8'd4, 30, 1'b0, 1'b1);
    run_phase(8'd1,  8'd3, 20, 1'b0, 1'b0);
    // Zero counts clamp up to one of each.
    run_phase(8'd0,  8'd0, 15, 1'b0, 1'b0);
    run_phase(8'd32, 8'd4, 10, 1'b0, 1'b0);
    // Counts above the limits clamp down to 32 and 4.
    run_phase(8'd63, 8'd7,  8, 1'b0, 1'b0);
    // Upper data bits set; only the low bits reach the registers.
    run_phase(8'hC5, 8'hFA, 20, 1'b0, 1'b0);
    // A stretch with no idling on either side.
    run_phase(8'd3,  8'd2, 30, 1'b1, 1'b0);
    repeat (3) begin
      run_phase(CFG_DATA_W'($urandom_range(1, 12)), CFG_DATA_W'($urandom_range(1, 4)),
                15, 1'b0, 1'b0);
    end
    settle();

    $display("Covered %0d input beats, %0d of them points, over %0d register settings.",
             beats_sent, sb.points_evaluated, settings_run);
    $display("Checked %0d result beats, %0d of them saturated; %0d mismatches.",
             sb.results_seen, sb.saturations, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/clse_pkg.sv
design/clse_in_if.sv
design/clse_out_if.sv
design/clse_cfg_if.sv
design/clse_ram.sv
design/clse_datapath.sv
design/clse_ctrl.sv
design/chebyshev_series_eval.sv
test/chebyshev_series_eval_test.sv
